// ===== rtl/tdu_pkg.sv =====
// ----------------------------------------------------------------------------
// tdu_pkg
// types, codes and constants shared by the time base / decrementer unit
// ----------------------------------------------------------------------------
package tdu_pkg;

  // host time is split into whole seconds and leftover ns for conversion
  localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;
  localparam logic [31:0] DEFAULT_RATE_HZ = 32'd25000000;
  localparam logic [63:0] HIGH_HALF_MASK  = 64'hFFFFFFFF00000000;

  // divider: 2^61 / 1e9 rounded down, and one to four seconds for the fix-up
  localparam logic [31:0] RECIP_NS_PER_SEC = 32'd2305843009;
  localparam logic [32:0] NS_PER_SEC_X1    = 33'd1000000000;
  localparam logic [32:0] NS_PER_SEC_X2    = 33'd2000000000;
  localparam logic [32:0] NS_PER_SEC_X3    = 33'd3000000000;
  localparam logic [32:0] NS_PER_SEC_X4    = 33'd4000000000;

  // command queue between front and back
  localparam int          CMDQ_DEPTH = 2;
  localparam int          CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int          CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_POLL       = 3'd0,
    ACT_READ_TB    = 3'd1,
    ACT_READ_DEC   = 3'd2,
    ACT_WRITE_DEC  = 3'd3,
    ACT_WRITE_TBL  = 3'd4,
    ACT_WRITE_TBU  = 3'd5,
    ACT_CLEAR_PEND = 3'd6
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [55:0] host_time_ns;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        interrupt_pending;
    logic        fired_now;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        need_tb;
    logic        check;
    logic        rd_tb;
    logic        rd_dec;
    logic        wr_dec;
    logic        wr_tbl;
    logic        wr_tbu;
    logic        clr_pend;
    logic [55:0] ns;
    logic [31:0] data;
  } cmd_t;

  // dividend must stay below 1e9 * 2^32 so the quotient fits 32 bits
  typedef struct packed {
    logic        start;
    logic [61:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
    logic [29:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_NS,
    ST_MUL_Q,
    ST_MUL_R,
    ST_DIV_R,
    ST_WAIT_R,
    ST_SUM,
    ST_TB,
    ST_ELAPSED,
    ST_APPLY
  } exec_state_t;

endpackage

// ===== rtl/tdu_front.sv =====
// ----------------------------------------------------------------------------
// tdu_front
// accepts items, decodes the action and queues commands for the back end
// ----------------------------------------------------------------------------
module tdu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tdu_pkg::in_item_t   request,
  output logic                cmd_valid,
  output tdu_pkg::cmd_t       cmd,
  input  logic                cmd_pop
);

  tdu_pkg::cmd_t                     cls;
  tdu_pkg::cmd_t                     entries [tdu_pkg::CMDQ_DEPTH];
  logic [tdu_pkg::CMDQ_PTR_W-1:0]    wr_ptr;
  logic [tdu_pkg::CMDQ_PTR_W-1:0]    rd_ptr;
  logic [tdu_pkg::CMDQ_CNT_W-1:0]    count;
  logic                              accept;

  always_comb begin
    cls      = '0;
    cls.ns   = request.host_time_ns;
    cls.data = request.write_data;
    unique case (tdu_pkg::action_t'(request.action))
      tdu_pkg::ACT_POLL: begin
        cls.need_tb = 1'b1;
        cls.check   = 1'b1;
      end
      tdu_pkg::ACT_READ_TB: begin
        cls.need_tb = 1'b1;
        cls.check   = 1'b1;
        cls.rd_tb   = 1'b1;
      end
      tdu_pkg::ACT_READ_DEC: begin
        cls.need_tb = 1'b1;
        cls.check   = 1'b1;
        cls.rd_dec  = 1'b1;
      end
      tdu_pkg::ACT_WRITE_DEC: begin
        cls.need_tb = 1'b1;
        cls.wr_dec  = 1'b1;
      end
      tdu_pkg::ACT_WRITE_TBL: begin
        cls.need_tb = 1'b1;
        cls.wr_tbl  = 1'b1;
      end
      tdu_pkg::ACT_WRITE_TBU: begin
        cls.need_tb = 1'b1;
        cls.wr_tbu  = 1'b1;
      end
      tdu_pkg::ACT_CLEAR_PEND: begin
        cls.clr_pend = 1'b1;
      end
      default: begin
        // unused code: no flags, the item only produces a result with zero read data and the current pending flag
      end
    endcase
  end

  assign full      = (count == tdu_pkg::CMDQ_CNT_W'(tdu_pkg::CMDQ_DEPTH));
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + tdu_pkg::CMDQ_PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + tdu_pkg::CMDQ_PTR_W'(1);
      end
      if (accept && !cmd_pop) begin
        count <= count + tdu_pkg::CMDQ_CNT_W'(1);
      end else if (!accept && cmd_pop) begin
        count <= count - tdu_pkg::CMDQ_CNT_W'(1);
      end
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule

// ===== rtl/tdu_div.sv =====
// ----------------------------------------------------------------------------
// tdu_div
// divide by one second in ns: reciprocal estimate, back multiply, fix-up
// ----------------------------------------------------------------------------
module tdu_div (
  input  logic                clk,
  input  logic                rst,
  input  tdu_pkg::div_req_t   req,
  output tdu_pkg::div_rsp_t   rsp
);

  logic [61:0] dvd;
  logic [3:0]  stg;
  logic [62:0] recip_p;
  logic [31:0] q_est;
  logic [32:0] back_p;
  logic [32:0] rem_raw;
  logic [2:0]  fix_k;
  logic [32:0] fix_sub;
  logic [31:0] quo;
  logic [29:0] rem;

  // the estimate never overshoots and is at most four short
  always_comb begin
    if (rem_raw >= tdu_pkg::NS_PER_SEC_X4) begin
      fix_k   = 3'd4;
      fix_sub = tdu_pkg::NS_PER_SEC_X4;
    end else if (rem_raw >= tdu_pkg::NS_PER_SEC_X3) begin
      fix_k   = 3'd3;
      fix_sub = tdu_pkg::NS_PER_SEC_X3;
    end else if (rem_raw >= tdu_pkg::NS_PER_SEC_X2) begin
      fix_k   = 3'd2;
      fix_sub = tdu_pkg::NS_PER_SEC_X2;
    end else if (rem_raw >= tdu_pkg::NS_PER_SEC_X1) begin
      fix_k   = 3'd1;
      fix_sub = tdu_pkg::NS_PER_SEC_X1;
    end else begin
      fix_k   = 3'd0;
      fix_sub = '0;
    end
  end

  // one stage per cycle; the remainder is below 2^33 so low bits suffice
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
    end
    if (stg[0]) begin
      recip_p <= 63'(dvd[61:30]) * 63'(tdu_pkg::RECIP_NS_PER_SEC);
    end
    if (stg[1]) begin
      q_est  <= recip_p[62:31];
      back_p <= 33'(recip_p[62:31]) * 33'(tdu_pkg::NS_PER_SEC);
    end
    if (stg[2]) begin
      rem_raw <= dvd[32:0] - back_p;
    end
    if (stg[3]) begin
      quo <= q_est + 32'(fix_k);
      rem <= 30'(rem_raw - fix_sub);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
    end else if (req.start) begin
      stg <= 4'b0001;
    end else begin
      stg <= {stg[2:0], 1'b0};
    end
  end

  assign rsp.busy      = |stg;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  a_one_stage: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stg))
    else $error("divider has more than one stage active");

endmodule

// ===== rtl/tdu_exec.sv =====
// ----------------------------------------------------------------------------
// tdu_exec
// back end: ns to tick conversion, time base and decrementer state, result
// ----------------------------------------------------------------------------
module tdu_exec (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         rate,
  input  logic                cmd_valid,
  input  tdu_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  output tdu_pkg::div_req_t   div_req,
  input  tdu_pkg::div_rsp_t   div_rsp,
  input  logic                pop,
  output logic                empty,
  output tdu_pkg::out_item_t  response
);

  tdu_pkg::exec_state_t state;
  tdu_pkg::exec_state_t state_next;

  tdu_pkg::cmd_t        cmd_r;
  logic [61:0]          mul_p;
  logic [29:0]          mul_a;
  logic [59:0]          qf;
  logic [63:0]          ticks;
  logic [63:0]          tb;
  logic [63:0]          elapsed;

  logic [63:0]          base_offset;
  logic [63:0]          dec_start_ticks;
  logic [31:0]          dec_written;
  logic                 dec_armed;
  logic                 pending_flag;

  logic                 out_valid;
  tdu_pkg::out_item_t   out_item;

  logic                 mul_sel_q;
  logic                 mul_en;
  logic                 apply;
  logic                 fire;
  logic [63:0]          rd_value;
  logic                 pending_after;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tdu_pkg::ST_IDLE:    if (cmd_valid) state_next = tdu_pkg::ST_LOAD;
      tdu_pkg::ST_LOAD:    state_next = cmd_r.need_tb ? tdu_pkg::ST_DIV_NS : tdu_pkg::ST_APPLY;
      tdu_pkg::ST_DIV_NS:  if (!div_rsp.busy) state_next = tdu_pkg::ST_MUL_Q;
      tdu_pkg::ST_MUL_Q:   state_next = tdu_pkg::ST_MUL_R;
      tdu_pkg::ST_MUL_R:   state_next = tdu_pkg::ST_DIV_R;
      tdu_pkg::ST_DIV_R:   state_next = tdu_pkg::ST_WAIT_R;
      tdu_pkg::ST_WAIT_R:  if (!div_rsp.busy) state_next = tdu_pkg::ST_SUM;
      tdu_pkg::ST_SUM:     state_next = tdu_pkg::ST_TB;
      tdu_pkg::ST_TB:      state_next = tdu_pkg::ST_ELAPSED;
      tdu_pkg::ST_ELAPSED: state_next = tdu_pkg::ST_APPLY;
      tdu_pkg::ST_APPLY:   if (!out_valid) state_next = tdu_pkg::ST_IDLE;
      default:             state_next = tdu_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop   = 1'b0;
    div_req   = '0;
    mul_sel_q = 1'b0;
    mul_en    = 1'b0;
    apply     = 1'b0;
    unique case (state)
      tdu_pkg::ST_IDLE: cmd_pop = cmd_valid;
      tdu_pkg::ST_LOAD: begin
        div_req.start    = cmd_r.need_tb;
        div_req.dividend = {6'd0, cmd_r.ns};
      end
      tdu_pkg::ST_MUL_Q: begin
        mul_en    = 1'b1;
        mul_sel_q = 1'b1;
      end
      tdu_pkg::ST_MUL_R: mul_en = 1'b1;
      tdu_pkg::ST_DIV_R: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p;
      end
      tdu_pkg::ST_APPLY: apply = !out_valid;
      default: begin
      end
    endcase
  end

  // one shared multiplier: whole seconds, then the leftover ns
  assign mul_a = mul_sel_q ? {2'b00, div_rsp.quotient[27:0]} : div_rsp.remainder;

  // expiry check and read value
  assign fire = cmd_r.check && dec_armed && (elapsed > {32'd0, dec_written});

  always_comb begin
    rd_value = '0;
    if (cmd_r.rd_tb) begin
      rd_value = tb;
    end else if (cmd_r.rd_dec) begin
      rd_value = {32'd0, dec_written - elapsed[31:0]};
    end
  end

  assign pending_after = fire ? 1'b1 : (cmd_r.clr_pend ? 1'b0 : pending_flag);

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    if (mul_en) begin
      mul_p <= 62'(mul_a) * 62'(rate);
    end
    if (state == tdu_pkg::ST_MUL_R) begin
      qf <= mul_p[59:0];
    end
    if (state == tdu_pkg::ST_SUM) begin
      ticks <= 64'(qf) + 64'(div_rsp.quotient);
    end
    if (state == tdu_pkg::ST_TB) begin
      tb <= ticks + base_offset;
    end
    if (state == tdu_pkg::ST_ELAPSED) begin
      elapsed <= tb - dec_start_ticks;
    end
    if (apply) begin
      out_item.read_data         <= rd_value;
      out_item.interrupt_pending <= pending_after;
      out_item.fired_now         <= fire;
    end
  end

  // architectural state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tdu_pkg::ST_IDLE;
      base_offset     <= '0;
      dec_start_ticks <= '0;
      dec_written     <= '0;
      dec_armed       <= 1'b0;
      pending_flag    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (apply) begin
        out_valid    <= 1'b1;
        pending_flag <= pending_after;
        if (fire) begin
          dec_armed <= 1'b0;
        end
        if (cmd_r.wr_dec) begin
          dec_start_ticks <= tb;
          dec_written     <= cmd_r.data;
          dec_armed       <= 1'b1;
        end
        // new offset = new tb value - raw ticks
        if (cmd_r.wr_tbl) begin
          base_offset <= ((tb & tdu_pkg::HIGH_HALF_MASK) | {32'd0, cmd_r.data}) - ticks;
        end
        if (cmd_r.wr_tbu) begin
          base_offset <= {cmd_r.data, tb[31:0]} - ticks;
        end
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid;
  assign response = out_item;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_fire_disarms: assert property (@(posedge clk) disable iff (rst)
    (apply && fire) |=> (!dec_armed && pending_flag && out_item.fired_now))
    else $error("expiry did not disarm and set pending");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(out_item)))
    else $error("waiting result lost or changed");

  a_apply_after_tb: assert property (@(posedge clk) disable iff (rst)
    (state == tdu_pkg::ST_APPLY && $past(state) != tdu_pkg::ST_APPLY && cmd_r.need_tb)
      |-> ($past(state) == tdu_pkg::ST_ELAPSED))
    else $error("time base command applied before conversion finished");

endmodule

// ===== rtl/timebase_decrementer_unit.sv =====
// ----------------------------------------------------------------------------
// timebase_decrementer_unit
// time base and decrementer driven by the host time of each access
// ----------------------------------------------------------------------------
// Each item carries an action and the host time in ns. The time base is
// floor(ns * rate / 1e9) plus a kept 64-bit offset, exact, modulo 2^64; a
// rate register of zero selects 25 MHz. One result item comes back per input
// item, in order. Items enter a two-entry command queue and are worked one at
// a time: an action that needs the time base goes from the head of the queue
// to a ready result through two passes of the shared divide-by-1e9 unit
// (reciprocal multiply, back multiply, subtract and a small fix-up) and the
// shared 30x32 multiplier; clear pending and the unused code skip the
// conversion. The result register holds one finished item, so the queue
// keeps filling while it waits to be popped. The rate register is written
// through cfg_write_en / cfg_write_data and should only change while no item
// is in flight.
module timebase_decrementer_unit (
  input  logic                clk,
  input  logic                rst,
  // input item queue side
  input  logic                push,
  output logic                full,
  input  tdu_pkg::in_item_t   request,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output tdu_pkg::out_item_t  response,
  // rate register
  input  logic                cfg_write_en,
  input  logic [31:0]         cfg_write_data
);

  logic                tick_rate_hz;
  logic [31:0]         tick_rate_reg;
  logic [31:0]         rate_eff;
  logic                cmd_valid;
  logic                cmd_pop;
  tdu_pkg::cmd_t       cmd;
  tdu_pkg::div_req_t   div_req;
  tdu_pkg::div_rsp_t   div_rsp;

  // rate register, reset to the default rate
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_reg <= tdu_pkg::DEFAULT_RATE_HZ;
    end else if (cfg_write_en) begin
      tick_rate_reg <= cfg_write_data;
    end
  end

  // zero rate falls back to the default
  assign tick_rate_hz = (tick_rate_reg != 32'd0);
  assign rate_eff     = tick_rate_hz ? tick_rate_reg : tdu_pkg::DEFAULT_RATE_HZ;

  // front: accept and classify
  tdu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // shared divide-by-one-second unit
  tdu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // back: conversion, state update, result register
  tdu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .rate      (rate_eff),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .pop       (pop),
    .empty     (empty),
    .response  (response)
  );

endmodule
